[sv/bls_pkg.sv]
// Shared widths, codes and line-state type for the line stepper.
package bls_pkg;

    localparam int COORD_W = 12;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int INC_W   = COORD_W + 2;
    localparam int ERR_W   = COORD_W + 3;
    localparam int COLOR_W = 4;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef struct packed {
        logic                     x_major;
        logic                     minor_down;
        logic [COORD_W-1:0]       cur_x;
        logic [COORD_W-1:0]       cur_y;
        logic [COORD_W-1:0]       major_end;
        logic signed [ERR_W-1:0]  err;
        logic [INC_W-1:0]         inc_no;
        logic signed [INC_W-1:0]  inc_with;
        logic [COLOR_W-1:0]       color;
    } t_line_state;

endpackage

[sv/bls_line_setup.sv]
// Line setup: orders endpoints, picks the major axis and seeds the error terms.
module bls_line_setup (
    input  logic signed [bls_pkg::COORD_W-1:0] i_x1,
    input  logic signed [bls_pkg::COORD_W-1:0] i_y1,
    input  logic signed [bls_pkg::COORD_W-1:0] i_x2,
    input  logic signed [bls_pkg::COORD_W-1:0] i_y2,
    input  logic [bls_pkg::COLOR_W-1:0]        i_color,
    output bls_pkg::t_line_state               o_state,
    output logic                               o_last
);

    logic signed [bls_pkg::DIFF_W-1:0] dx;
    logic signed [bls_pkg::DIFF_W-1:0] dy;
    logic [bls_pkg::DIFF_W-1:0]        ax;
    logic [bls_pkg::DIFF_W-1:0]        ay;
    logic [bls_pkg::DIFF_W-1:0]        maj;
    logic [bls_pkg::DIFF_W-1:0]        mnr;
    logic                              x_major;
    logic                              swap;

    assign dx = bls_pkg::DIFF_W'(i_x2) - bls_pkg::DIFF_W'(i_x1);
    assign dy = bls_pkg::DIFF_W'(i_y2) - bls_pkg::DIFF_W'(i_y1);
    assign ax = dx[bls_pkg::DIFF_W-1] ? bls_pkg::DIFF_W'(-dx) : dx;
    assign ay = dy[bls_pkg::DIFF_W-1] ? bls_pkg::DIFF_W'(-dy) : dy;

    assign x_major = (ay <= ax);
    assign maj     = x_major ? ax : ay;
    assign mnr     = x_major ? ay : ax;
    // walk from the endpoint with the smaller major coordinate
    assign swap    = x_major ? dx[bls_pkg::DIFF_W-1] : dy[bls_pkg::DIFF_W-1];

    always_comb begin
        o_state.x_major    = x_major;
        o_state.minor_down = (dx != '0) && (dy != '0)
                             && (dx[bls_pkg::DIFF_W-1] != dy[bls_pkg::DIFF_W-1]);
        o_state.cur_x      = swap ? i_x2 : i_x1;
        o_state.cur_y      = swap ? i_y2 : i_y1;
        if (x_major) begin
            o_state.major_end = swap ? i_x1 : i_x2;
        end else begin
            o_state.major_end = swap ? i_y1 : i_y2;
        end
        o_state.err      = $signed({1'b0, mnr, 1'b0}) - $signed({2'b00, maj});
        o_state.inc_no   = {mnr, 1'b0};
        o_state.inc_with = $signed({mnr, 1'b0} - {maj, 1'b0});
        o_state.color    = i_color;
        o_last = x_major ? (o_state.cur_x == o_state.major_end)
                         : (o_state.cur_y == o_state.major_end);
    end

endmodule

[sv/bls_step.sv]
// One Bresenham step: decide the minor move, update the error, advance the major axis.
module bls_step (
    input  bls_pkg::t_line_state i_state,
    output bls_pkg::t_line_state o_state,
    output logic                 o_last
);

    logic                            take;
    logic signed [bls_pkg::ERR_W-1:0] err_add;
    logic [bls_pkg::COORD_W-1:0]     unit;
    logic [bls_pkg::COORD_W-1:0]     major_n;

    // x-major steps on err >= 0, y-major only on err > 0
    assign take = i_state.x_major ? !i_state.err[bls_pkg::ERR_W-1]
                                  : (!i_state.err[bls_pkg::ERR_W-1] && (i_state.err != '0));
    assign err_add = take ? bls_pkg::ERR_W'(i_state.inc_with)
                          : $signed(bls_pkg::ERR_W'(i_state.inc_no));
    assign unit = i_state.minor_down ? '1 : bls_pkg::COORD_W'(1);
    assign major_n = (i_state.x_major ? i_state.cur_x : i_state.cur_y)
                     + bls_pkg::COORD_W'(1);

    always_comb begin
        o_state     = i_state;
        o_state.err = i_state.err + err_add;
        if (i_state.x_major) begin
            o_state.cur_x = major_n;
            o_state.cur_y = take ? i_state.cur_y + unit : i_state.cur_y;
        end else begin
            o_state.cur_y = major_n;
            o_state.cur_x = take ? i_state.cur_x + unit : i_state.cur_x;
        end
        o_last = (major_n == i_state.major_end);
    end

endmodule

[sv/bresenham_line_stepper_core.sv]
// Bresenham line stepper: input register, one setup/step pass, result register.
// An input beat passes through the input register, then the result register.
// Throughput: one beat per cycle unless stalled; the line-state loop is one step wide.
// Input stalls only while the result register holds a beat that is itself stalled.
// Reset (synchronous, active low) empties both registers and leaves no line in progress.
module bresenham_line_stepper_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_kind,
    input  logic signed [bls_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [bls_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [bls_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [bls_pkg::COORD_W-1:0] i_end_y,
    input  logic [bls_pkg::COLOR_W-1:0]        i_pen_color,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_valid_res,
    output logic signed [bls_pkg::COORD_W-1:0] o_pixel_x,
    output logic signed [bls_pkg::COORD_W-1:0] o_pixel_y,
    output logic [bls_pkg::COLOR_W-1:0]        o_pixel_color,
    output logic                               o_last
);

    logic                               r_in_valid;
    logic                               r_in_kind;
    logic signed [bls_pkg::COORD_W-1:0] r_in_x1;
    logic signed [bls_pkg::COORD_W-1:0] r_in_y1;
    logic signed [bls_pkg::COORD_W-1:0] r_in_x2;
    logic signed [bls_pkg::COORD_W-1:0] r_in_y2;
    logic [bls_pkg::COLOR_W-1:0]        r_in_color;

    logic                 r_busy;
    logic                 n_busy;
    bls_pkg::t_line_state r_line;
    bls_pkg::t_line_state n_line;

    logic                        r_out_valid;
    logic                        r_valid_res;
    logic                        n_valid_res;
    logic [bls_pkg::COORD_W-1:0] r_px;
    logic [bls_pkg::COORD_W-1:0] r_py;
    logic [bls_pkg::COLOR_W-1:0] r_pcolor;
    logic                        r_last;
    logic                        n_last;

    bls_pkg::t_line_state setup_state;
    logic                 setup_last;
    bls_pkg::t_line_state step_state;
    logic                 step_last;

    logic out_free;
    logic fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    bls_line_setup u_setup (
        .i_x1    (r_in_x1),
        .i_y1    (r_in_y1),
        .i_x2    (r_in_x2),
        .i_y2    (r_in_y2),
        .i_color (r_in_color),
        .o_state (setup_state),
        .o_last  (setup_last)
    );

    bls_step u_step (
        .i_state (r_line),
        .o_state (step_state),
        .o_last  (step_last)
    );

    always_comb begin
        n_line      = r_line;
        n_busy      = r_busy;
        n_valid_res = 1'b0;
        n_last      = 1'b0;
        if (r_in_kind == bls_pkg::KIND_START) begin
            // a start drops any running line
            n_line      = setup_state;
            n_last      = setup_last;
            n_busy      = !setup_last;
            n_valid_res = 1'b1;
        end else if (r_busy) begin
            n_line      = step_state;
            n_last      = step_last;
            n_busy      = !step_last;
            n_valid_res = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_kind  <= i_kind;
            r_in_x1    <= i_start_x;
            r_in_y1    <= i_start_y;
            r_in_x2    <= i_end_x;
            r_in_y2    <= i_end_y;
            r_in_color <= i_pen_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_line <= '0;
        end else if (fire) begin
            r_busy <= n_busy;
            r_line <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (fire) begin
            r_valid_res <= n_valid_res;
            r_last      <= n_last;
            // idle advance reports an all-zero pixel
            r_px        <= n_valid_res ? n_line.cur_x : '0;
            r_py        <= n_valid_res ? n_line.cur_y : '0;
            r_pcolor    <= n_valid_res ? n_line.color : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_valid_res   = r_valid_res;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcolor;
    assign o_last        = r_last;

    a_idle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_in_kind == bls_pkg::KIND_ADVANCE) && !r_busy
        |=> o_out_valid && !o_valid_res && !o_last)
        else $error("advance while idle produced a pixel");

    a_busy_tracks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |-> (o_last == !r_busy))
        else $error("line state disagrees with the last flag of the held beat");

    a_hold_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(r_busy) && $stable(r_line))
        else $error("line state moved while the result beat was stalled");

endmodule

[tb/sv/bresenham_line_stepper_core_tb.sv]
// Self-checking testbench for the Bresenham line stepper core.
`timescale 1ns / 1ps

module bresenham_line_stepper_core_tb;

    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 150;
    localparam int LATENCY      = 2;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int COORD_MIN    = -(1 << (bls_pkg::COORD_W - 1));
    localparam int COORD_MAX    = (1 << (bls_pkg::COORD_W - 1)) - 1;

    typedef struct packed {
        logic                        valid_res;
        logic [bls_pkg::COORD_W-1:0] x;
        logic [bls_pkg::COORD_W-1:0] y;
        logic [bls_pkg::COLOR_W-1:0] color;
        logic                        last;
    } t_pixel;

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Line-state predictor plus the queue of pixels it has promised.
    class pixel_scoreboard;
        bit               busy;
        bit               x_major;
        bit               minor_down;
        int               cur_x;
        int               cur_y;
        int               major_end;
        int               err;
        int               inc_no;
        int               inc_with;
        logic [bls_pkg::COLOR_W-1:0] color;
        t_pixel           expected_q[$];
        int               n_fail;

        function new();
            busy       = 1'b0;
            x_major    = 1'b0;
            minor_down = 1'b0;
            cur_x      = 0;
            cur_y      = 0;
            major_end  = 0;
            err        = 0;
            inc_no     = 0;
            inc_with   = 0;
            color      = '0;
            n_fail     = 0;
        endfunction

        function t_pixel make_pixel(bit last);
            t_pixel p;
            p.valid_res = 1'b1;
            p.x         = cur_x[bls_pkg::COORD_W-1:0];
            p.y         = cur_y[bls_pkg::COORD_W-1:0];
            p.color     = color;
            p.last      = last;
            return p;
        endfunction

        function void note_beat(logic kind, int x1, int y1, int x2, int y2,
                                logic [bls_pkg::COLOR_W-1:0] pc);
            int dx;
            int dy;
            int ax;
            int ay;
            int unit;
            bit last;
            if (kind == bls_pkg::KIND_START) begin
                dx         = x2 - x1;
                dy         = y2 - y1;
                ax         = mag(dx);
                ay         = mag(dy);
                color      = pc;
                minor_down = (dx != 0 && dy != 0) && ((dx < 0) != (dy < 0));
                if (ay <= ax) begin
                    x_major = 1'b1;
                    if (dx >= 0) begin
                        cur_x = x1; cur_y = y1; major_end = x2;
                    end else begin
                        cur_x = x2; cur_y = y2; major_end = x1;
                    end
                    err      = 2 * ay - ax;
                    inc_no   = 2 * ay;
                    inc_with = 2 * (ay - ax);
                    last     = (cur_x == major_end);
                end else begin
                    x_major = 1'b0;
                    if (dy >= 0) begin
                        cur_x = x1; cur_y = y1; major_end = y2;
                    end else begin
                        cur_x = x2; cur_y = y2; major_end = y1;
                    end
                    err      = 2 * ax - ay;
                    inc_no   = 2 * ax;
                    inc_with = 2 * (ax - ay);
                    last     = (cur_y == major_end);
                end
                busy = !last;
                expected_q.push_back(make_pixel(last));
            end else if (!busy) begin
                expected_q.push_back('0);
            end else begin
                unit = minor_down ? -1 : 1;
                // x-major steps on a zero error, y-major does not
                if (x_major) begin
                    if (err < 0) begin
                        err += inc_no;
                    end else begin
                        cur_y += unit;
                        err   += inc_with;
                    end
                    cur_x += 1;
                    last = (cur_x == major_end);
                end else begin
                    if (err <= 0) begin
                        err += inc_no;
                    end else begin
                        cur_x += unit;
                        err   += inc_with;
                    end
                    cur_y += 1;
                    last = (cur_y == major_end);
                end
                if (last) busy = 1'b0;
                expected_q.push_back(make_pixel(last));
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
                n_fail++;
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected pixel beat: expected none, actual %p", $time, got);
                n_fail++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("valid_res", int'(want.valid_res), int'(got.valid_res));
            compare_field("pixel_x", int'($signed(want.x)), int'($signed(got.x)));
            compare_field("pixel_y", int'($signed(want.y)), int'($signed(got.y)));
            compare_field("pixel_color", int'(want.color), int'(got.color));
            compare_field("last", int'(want.last), int'(got.last));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n       = 1'b0;
    logic                               i_in_valid    = 1'b0;
    logic                               o_in_stall;
    logic                               i_kind        = bls_pkg::KIND_START;
    logic signed [bls_pkg::COORD_W-1:0] i_start_x     = '0;
    logic signed [bls_pkg::COORD_W-1:0] i_start_y     = '0;
    logic signed [bls_pkg::COORD_W-1:0] i_end_x       = '0;
    logic signed [bls_pkg::COORD_W-1:0] i_end_y       = '0;
    logic [bls_pkg::COLOR_W-1:0]        i_pen_color   = '0;
    logic                               o_out_valid;
    logic                               i_out_stall   = 1'b0;
    logic                               o_valid_res;
    logic signed [bls_pkg::COORD_W-1:0] o_pixel_x;
    logic signed [bls_pkg::COORD_W-1:0] o_pixel_y;
    logic [bls_pkg::COLOR_W-1:0]        o_pixel_color;
    logic                               o_last;

    pixel_scoreboard sb = new();

    bit quiet_tail = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;
    int gap_odds   = 0;
    int items_sent = 0;
    int cycle_count = 0;

    bresenham_line_stepper_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_pen_color   (i_pen_color),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_valid_res   (o_valid_res),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Compare every accepted pixel beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.valid_res = o_valid_res;
            got.x         = o_pixel_x;
            got.y         = o_pixel_y;
            got.color     = o_pixel_color;
            got.last      = o_last;
            sb.check_pixel(got);
        end
    end

    // Pixel sink: random stall bursts, one long hold-off, none in the tail.
    initial begin : pixel_sink
        int odds;
        int cnt;
        odds = 0;
        cnt  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            cnt++;
            if (cnt % 64 == 0) odds = $urandom_range(0, 2);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet_tail && odds != 0 && $urandom_range(0, 3 * odds) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // After an optional random gap, offer one beat, hold it until accepted, then record it.
    task automatic drive_beat(input logic kind,
                              input logic signed [bls_pkg::COORD_W-1:0] sx,
                              input logic signed [bls_pkg::COORD_W-1:0] sy,
                              input logic signed [bls_pkg::COORD_W-1:0] ex,
                              input logic signed [bls_pkg::COORD_W-1:0] ey,
                              input logic [bls_pkg::COLOR_W-1:0] pc);
        if (!quiet_tail && gap_odds != 0 && $urandom_range(0, 8 / gap_odds) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_start_x   <= sx;
        i_start_y   <= sy;
        i_end_x     <= ex;
        i_end_y     <= ey;
        i_pen_color <= pc;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(kind, int'(sx), int'(sy), int'(ex), int'(ey), pc);
        items_sent++;
    endtask

    // Advance beats carry junk in the endpoint fields.
    task automatic send_advance();
        drive_beat(bls_pkg::KIND_ADVANCE,
                   bls_pkg::COORD_W'($urandom_range(0, 4095)),
                   bls_pkg::COORD_W'($urandom_range(0, 4095)),
                   bls_pkg::COORD_W'($urandom_range(0, 4095)),
                   bls_pkg::COORD_W'($urandom_range(0, 4095)),
                   bls_pkg::COLOR_W'($urandom_range(0, 15)));
    endtask

    task automatic draw_line(input int x1, input int y1, input int x2, input int y2,
                             input int pc, input int n_adv);
        drive_beat(bls_pkg::KIND_START, bls_pkg::COORD_W'(x1), bls_pkg::COORD_W'(y1),
                   bls_pkg::COORD_W'(x2), bls_pkg::COORD_W'(y2), bls_pkg::COLOR_W'(pc));
        repeat (n_adv) send_advance();
    endtask

    initial begin : stimulus
        int base;
        int form;
        int x1;
        int y1;
        int x2;
        int y2;
        int dx;
        int dy;
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_odds = 1;

        // Directed: idle advance, single pixel, tie rules, reordering, extremes.
        drive_beat(bls_pkg::KIND_ADVANCE, '1, '1, '1, '1, '1);
        draw_line(5, -7, 5, -7, 15, 1);
        draw_line(0, 0, 2, 1, 3, 2);
        draw_line(0, 0, 1, 2, 6, 2);
        draw_line(3, 3, 0, 0, 9, 3);
        draw_line(0, 0, 3, -1, 12, 3);
        draw_line(0, 4, 0, 0, 1, 1);
        draw_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 2);
        draw_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 15, 1);
        draw_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 10, 1);

        base = items_sent;
        hold_req = 1'b1;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (items_sent - base >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            gap_odds = $urandom_range(0, 2);
            form = $urandom_range(0, 9);
            x1 = int'($urandom_range(0, 4095)) + COORD_MIN;
            y1 = int'($urandom_range(0, 4095)) + COORD_MIN;
            if (form == 0) begin
                send_advance();
            end else if (form == 1) begin
                // long line across the plane, cut short
                draw_line(x1, y1, int'($urandom_range(0, 4095)) + COORD_MIN,
                          int'($urandom_range(0, 4095)) + COORD_MIN,
                          $urandom_range(0, 15), $urandom_range(0, 6));
            end else begin
                dx = int'($urandom_range(0, 24)) - 12;
                dy = int'($urandom_range(0, 24)) - 12;
                x2 = x1 + dx;
                y2 = y1 + dy;
                if (x2 > COORD_MAX || x2 < COORD_MIN) x2 = x1 - dx;
                if (y2 > COORD_MAX || y2 < COORD_MIN) y2 = y1 - dy;
                n = (mag(dx) > mag(dy)) ? mag(dx) : mag(dy);
                if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
                else if ($urandom_range(0, 2) == 0) n += $urandom_range(1, 2);
                draw_line(x1, y1, x2, y2, $urandom_range(0, 15), n);
            end
        end
        quiet_tail = 1'b1;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/bls_pkg.sv
sv/bls_line_setup.sv
sv/bls_step.sv
sv/bresenham_line_stepper_core.sv
tb/sv/bresenham_line_stepper_core_tb.sv
